### hw/rtl/itrd_pkg.sv
// Package for the integer to radix digits converter.
// Holds the shared types, character constants and the digit to character mapping.
// Used by itrd_divider and integer_to_radix_digits_core.
package itrd_pkg;

	typedef logic [6:0] radix_t;
	typedef logic [6:0] char_t;

	typedef struct packed {
		logic   done;
		radix_t rem;
	} div_stat_t;

	localparam radix_t RADIX_MIN    = 7'd2;
	localparam radix_t RADIX_MAX    = 7'd72;
	localparam radix_t RADIX_RESET  = 7'd16;
	localparam radix_t LETTER_LIMIT = 7'd10;
	localparam char_t  CHAR_ZERO    = 7'd48;
	localparam char_t  CHAR_UPPER_A = 7'd65;
	localparam char_t  CHAR_MINUS   = 7'd45;

	function automatic char_t digit_char(input radix_t d);
		char_t c;
		if (d >= LETTER_LIMIT) begin
			c = d - LETTER_LIMIT + CHAR_UPPER_A;
		end else begin
			c = d + CHAR_ZERO;
		end
		return c;
	endfunction

endpackage

### hw/rtl/itrd_ram.sv
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module itrd_ram #(
	parameter int WIDTH = 7,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### hw/rtl/itrd_divider.sv
// Bit-serial restoring divider: one quotient bit per cycle.
// Divides an unsigned dividend by a 7-bit radix; depends on itrd_pkg.
module itrd_divider
	import itrd_pkg::*;
#(
	parameter int VALUE_WIDTH = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [VALUE_WIDTH-1:0] dividend,
	input  radix_t                 divisor,
	output logic [VALUE_WIDTH-1:0] quotient,
	output div_stat_t              stat
);

	localparam int CW = $clog2(VALUE_WIDTH);

	logic [VALUE_WIDTH-1:0] shift_q;
	radix_t                 rem_q;
	radix_t                 div_q;
	logic [CW-1:0]          cnt_q;
	logic                   busy_q;

	logic [7:0]             trial;
	logic [7:0]             diff;
	logic                   ge;
	radix_t                 rem_next;
	logic [VALUE_WIDTH-1:0] shift_next;

	always_comb begin
		trial      = {rem_q, shift_q[VALUE_WIDTH-1]};
		ge         = trial >= {1'b0, div_q};
		diff       = trial - {1'b0, div_q};
		rem_next   = ge ? diff[6:0] : trial[6:0];
		shift_next = {shift_q[VALUE_WIDTH-2:0], ge};
	end

	assign quotient  = shift_next;
	assign stat.rem  = rem_next;
	assign stat.done = busy_q && (cnt_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q <= '0;
			rem_q   <= '0;
			div_q   <= RADIX_RESET;
			cnt_q   <= '0;
			busy_q  <= 1'b0;
		end else if (start) begin
			shift_q <= dividend;
			rem_q   <= '0;
			div_q   <= divisor;
			cnt_q   <= CW'(VALUE_WIDTH - 1);
			busy_q  <= 1'b1;
		end else if (busy_q) begin
			shift_q <= shift_next;
			rem_q   <= rem_next;
			cnt_q   <= cnt_q - 1'b1;
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end
		end
	end

endmodule

### hw/rtl/integer_to_radix_digits_core.sv
// Converts a signed integer to its character string in radix 2 to 72, most significant first.
// Each digit comes from the bit-serial divider and is written to the digit store; then a '-' is
// sent if the value is negative, and each digit passes through store read, load and hand-over.
// A new value is taken only once the last character of the previous one has been handed over.
// Reset sets the radix to 16 and empties the output; the digit store is not cleared.
// Depends on itrd_pkg, itrd_divider and itrd_ram.
module integer_to_radix_digits_core
	import itrd_pkg::*;
#(
	parameter int VALUE_WIDTH = 32,
	parameter int MAX_DIGITS  = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [6:0]                    cfg_wdata,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [VALUE_WIDTH-1:0] value,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [6:0]                    char_code,
	output logic                          last_char
);

	localparam int AW = $clog2(MAX_DIGITS);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_DIV  = 3'd1;
	localparam logic [2:0] ST_SIGN = 3'd2;
	localparam logic [2:0] ST_READ = 3'd3;
	localparam logic [2:0] ST_LOAD = 3'd4;
	localparam logic [2:0] ST_OUT  = 3'd5;

	logic [2:0]    state_q;
	radix_t        radix_q;
	radix_t        base_q;
	logic          neg_q;
	logic [AW-1:0] count_q;
	logic [AW-1:0] ptr_q;
	logic          out_valid_q;
	char_t         char_q;
	logic          last_q;

	logic [VALUE_WIDTH-1:0] value_u;
	logic [VALUE_WIDTH-1:0] mag;
	radix_t                 sat_radix;
	logic                   in_accept;
	logic                   more;
	logic                   div_start;
	logic [VALUE_WIDTH-1:0] div_dividend;
	radix_t                 div_divisor;
	logic [VALUE_WIDTH-1:0] div_quot;
	div_stat_t              div_stat;
	logic                   ram_we;
	char_t                  ram_rdata;

	always_comb begin
		value_u = $unsigned(value);
		mag     = value_u[VALUE_WIDTH-1] ? (~value_u + 1'b1) : value_u;
		if (radix_q < RADIX_MIN) begin
			sat_radix = RADIX_MIN;
		end else if (radix_q > RADIX_MAX) begin
			sat_radix = RADIX_MAX;
		end else begin
			sat_radix = radix_q;
		end
		in_accept    = in_valid && (state_q == ST_IDLE);
		more         = (div_quot != '0) && (count_q != AW'(MAX_DIGITS - 1));
		div_start    = in_accept || ((state_q == ST_DIV) && div_stat.done && more);
		div_dividend = in_accept ? mag : div_quot;
		div_divisor  = in_accept ? sat_radix : base_q;
		ram_we       = (state_q == ST_DIV) && div_stat.done;
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign char_code = char_q;
	assign last_char = last_q;

	itrd_divider #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_divider (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(div_dividend),
		.divisor (div_divisor),
		.quotient(div_quot),
		.stat    (div_stat)
	);

	itrd_ram #(
		.WIDTH(7),
		.DEPTH(MAX_DIGITS)
	) u_digit_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(count_q),
		.wdata(digit_char(div_stat.rem)),
		.raddr(ptr_q),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q <= RADIX_RESET;
		end else if (cfg_we) begin
			radix_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			base_q      <= RADIX_RESET;
			neg_q       <= 1'b0;
			count_q     <= '0;
			ptr_q       <= '0;
			out_valid_q <= 1'b0;
			char_q      <= CHAR_ZERO;
			last_q      <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_accept) begin
						neg_q   <= value_u[VALUE_WIDTH-1];
						base_q  <= sat_radix;
						count_q <= '0;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_stat.done) begin
						ptr_q <= count_q;
						if (more) begin
							count_q <= count_q + 1'b1;
						end else if (neg_q) begin
							out_valid_q <= 1'b1;
							char_q      <= CHAR_MINUS;
							last_q      <= 1'b0;
							state_q     <= ST_SIGN;
						end else begin
							state_q <= ST_READ;
						end
					end
				end
				ST_SIGN: begin
					if (!out_stall) begin
						out_valid_q <= 1'b0;
						state_q     <= ST_READ;
					end
				end
				ST_READ: begin
					state_q <= ST_LOAD;
				end
				ST_LOAD: begin
					out_valid_q <= 1'b1;
					char_q      <= ram_rdata;
					last_q      <= (ptr_q == '0);
					state_q     <= ST_OUT;
				end
				ST_OUT: begin
					if (!out_stall) begin
						out_valid_q <= 1'b0;
						if (last_q) begin
							state_q <= ST_IDLE;
						end else begin
							ptr_q   <= ptr_q - 1'b1;
							state_q <= ST_READ;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

### test/testbench.sv
// Testbench for integer_to_radix_digits_core: signed values are converted at many radix settings
// and each character is checked against a local prediction of the expected string.
// Depends on itrd_pkg and the core RTL; needs no files or arguments.
module testbench
	import itrd_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int VALUE_BITS     = 32;
	localparam int DIGIT_LIMIT    = 32;
	localparam int SETTLE_CYCLES  = 16;
	localparam int HOLD_CYCLES    = 1500;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int RANDOM_PER_RADIX = 30;

	localparam logic [VALUE_BITS-1:0] MOST_NEGATIVE = 32'h8000_0000;
	localparam logic [VALUE_BITS-1:0] MOST_POSITIVE = 32'h7fff_ffff;

	typedef struct packed {
		char_t code;
		logic  last;
	} char_result_t;

	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         cfg_we = 1'b0;
	logic [6:0]                   cfg_wdata = RADIX_RESET;
	logic                         in_valid = 1'b0;
	logic                         in_stall;
	logic signed [VALUE_BITS-1:0] value = '0;
	logic                         out_valid;
	logic                         out_stall = 1'b0;
	logic [6:0]                   char_code;
	logic                         last_char;

	char_result_t expected_chars[$];
	char_result_t oldest_char;
	radix_t       radix_shadow = RADIX_RESET;
	int           mismatch_count = 0;
	int           quiet_cycles = 0;
	int           send_idle_pct = 28;
	int           recv_idle_pct = 64;
	int           hold_left = 0;
	logic         hold_toggle = 1'b0;
	logic         hold_seen = 1'b0;

	integer_to_radix_digits_core #(
		.VALUE_WIDTH(VALUE_BITS),
		.MAX_DIGITS (DIGIT_LIMIT)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.value    (value),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.char_code(char_code),
		.last_char(last_char)
	);

	always #5 clk = ~clk;

	function automatic void predict_string(input logic [VALUE_BITS-1:0] raw, input radix_t reg_radix);
		logic [VALUE_BITS-1:0] magnitude;
		logic [VALUE_BITS-1:0] digit;
		radix_t                base;
		char_t                 digits[$];
		int                    k;
		if (reg_radix < RADIX_MIN) begin
			base = RADIX_MIN;
		end else if (reg_radix > RADIX_MAX) begin
			base = RADIX_MAX;
		end else begin
			base = reg_radix;
		end
		magnitude = raw[VALUE_BITS-1] ? (0 - raw) : raw;
		do begin
			digit = magnitude % base;
			if (digit < LETTER_LIMIT) begin
				digits.push_back(CHAR_ZERO + digit[6:0]);
			end else begin
				digits.push_back(CHAR_UPPER_A + digit[6:0] - LETTER_LIMIT);
			end
			magnitude = magnitude / base;
		end while (magnitude != 0 && digits.size() < DIGIT_LIMIT);
		if (raw[VALUE_BITS-1]) begin
			expected_chars.push_back('{code: CHAR_MINUS, last: 1'b0});
		end
		for (k = digits.size(); k > 0; k--) begin
			expected_chars.push_back('{code: digits[k-1], last: (k == 1)});
		end
	endfunction

	// Prediction happens at input acceptance and checking at output acceptance, both sampled
	// at the same clock edge on which the design samples them.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_we) begin
				radix_shadow = cfg_wdata;
			end
			if (in_valid && !in_stall) begin
				predict_string(value, radix_shadow);
			end
			if (out_valid && !out_stall) begin
				if (expected_chars.size() == 0) begin
					$display("%0t: unexpected character, expected none, actual %h last %b",
						$time, char_code, last_char);
					mismatch_count++;
				end else begin
					oldest_char = expected_chars.pop_front();
					if (char_code !== oldest_char.code) begin
						$display("%0t: char_code mismatch, expected %h, actual %h",
							$time, oldest_char.code, char_code);
						mismatch_count++;
					end
					if (last_char !== oldest_char.last) begin
						$display("%0t: last_char mismatch, expected %b, actual %b",
							$time, oldest_char.last, last_char);
						mismatch_count++;
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		if (hold_toggle != hold_seen) begin
			hold_seen <= hold_toggle;
			hold_left <= HOLD_CYCLES;
			out_stall <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic offer_value(input logic [VALUE_BITS-1:0] v);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		value    <= v;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic write_radix(input logic [6:0] r);
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_chars.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= r;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [VALUE_BITS-1:0] pick_value();
		int unsigned           w;
		logic [VALUE_BITS-1:0] v;
		case ($urandom_range(9))
			0: begin
				case ($urandom_range(3))
					0: v = '0;
					1: v = MOST_NEGATIVE;
					2: v = MOST_POSITIVE;
					default: v = '1;
				endcase
			end
			1, 2: begin
				v = $urandom;
			end
			default: begin
				w = $urandom_range(31, 1);
				v = $urandom & ((32'd1 << w) - 1);
				if ($urandom_range(1)) begin
					v = 0 - v;
				end
			end
		endcase
		return v;
	endfunction

	task automatic test_reset_radix();
		offer_value(0);
		offer_value(1);
		offer_value('1);
		offer_value(MOST_POSITIVE);
		offer_value(MOST_NEGATIVE);
		offer_value(15);
		offer_value(-16);
	endtask

	task automatic test_radix_extremes();
		write_radix(RADIX_MIN);
		offer_value(MOST_NEGATIVE);
		offer_value(MOST_POSITIVE);
		offer_value('1);
		offer_value(0);
		offer_value(5);
		write_radix(RADIX_MAX);
		offer_value(71);
		offer_value(72);
		offer_value(-72);
		offer_value(MOST_NEGATIVE);
		offer_value(MOST_POSITIVE);
		write_radix(7'd10);
		offer_value(9);
		offer_value(10);
		offer_value(-123456789);
	endtask

	task automatic test_radix_saturation();
		write_radix(7'd0);
		offer_value(6);
		write_radix(7'd1);
		offer_value(3);
		write_radix(7'd127);
		offer_value(71);
		offer_value(5184);
		write_radix(7'd73);
		offer_value(72);
	endtask

	task automatic test_random_traffic();
		int         profile;
		int         slot;
		int         n;
		logic [6:0] r;
		for (profile = 0; profile < 3; profile++) begin
			case (profile)
				0: begin
					send_idle_pct <= 28;
					recv_idle_pct <= 64;
				end
				1: begin
					send_idle_pct <= 64;
					recv_idle_pct <= 28;
				end
				default: begin
					send_idle_pct <= 0;
					recv_idle_pct <= 0;
				end
			endcase
			for (slot = 0; slot < 4; slot++) begin
				case (slot)
					0: r = RADIX_MIN;
					1: r = RADIX_MAX;
					2: r = 7'($urandom_range(RADIX_MAX, RADIX_MIN));
					default: r = 7'($urandom_range(127, 0));
				endcase
				write_radix(r);
				for (n = 0; n < RANDOM_PER_RADIX; n++) begin
					offer_value(pick_value());
				end
			end
		end
	endtask

	task automatic test_output_hold();
		int n;
		write_radix(RADIX_MIN);
		send_idle_pct <= 0;
		recv_idle_pct <= 0;
		hold_toggle   <= ~hold_toggle;
		for (n = 0; n < 40; n++) begin
			offer_value(pick_value());
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_radix();
		test_radix_extremes();
		test_radix_saturation();
		test_random_traffic();
		test_output_hold();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_chars.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (expected_chars.size() != 0) begin
			$display("%0t: %0d characters never arrived", $time, expected_chars.size());
			mismatch_count++;
		end
		if (mismatch_count == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

### sim.f
hw/rtl/itrd_pkg.sv
hw/rtl/itrd_ram.sv
hw/rtl/itrd_divider.sv
hw/rtl/integer_to_radix_digits_core.sv
test/testbench.sv
